@@ sv/perfect_power_classifier_core_assert.svh @@
// Assertion macros used by the perfect power classifier controller.
`ifndef PERFECT_POWER_CLASSIFIER_CORE_ASSERT_SVH
`define PERFECT_POWER_CLASSIFIER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PPC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define PPC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/ppc_pkg.sv @@
// Shared constants and controller/datapath interface types for the classifier.
package ppc_pkg;

    localparam int VALUE_W = 32;               // input value width
    localparam int ROOT_W  = VALUE_W / 2;      // floor(sqrt) fits here
    localparam int RANGE_W = ROOT_W + 1;       // search bounds may reach 2^ROOT_W
    localparam int PROD_W  = VALUE_W + ROOT_W; // acc * base, no wrap
    localparam int BIT_W   = $clog2(ROOT_W);   // sqrt bit index
    localparam int CNT_W   = 5;                // exponent count register
    localparam int MASK_W  = 31;               // result mask width
    localparam int MCNT_W  = CNT_W + 1;        // multiply counter, up to 31

    localparam logic [CNT_W-1:0] CFG_RESET = CNT_W'(4);

    // Commands from controller to datapath
    typedef struct packed {
        logic load;        // capture request, clear mask and sqrt state
        logic sqrt_step;   // one bit of the integer square root
        logic search_init; // lo = 1, hi = root
        logic mid_calc;    // mid = midpoint, acc = 1, clear multiply count
        logic mul_acc;     // acc = acc * mid
        logic go_hi;       // hi = mid - 1
        logic go_lo;       // lo = mid + 1
        logic set_match;   // set mask bit for current exponent
        logic next_exp;    // advance to next exponent
        logic out_load;    // move mask into output register
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic count_zero;  // no exponent to test
        logic sqrt_last;   // final sqrt bit in progress
        logic range_ok;    // hi >= lo
        logic prod_gt;     // product exceeds value
        logic prod_eq;     // product equals value
        logic mul_last;    // this multiply completes mid^e
        logic exp_last;    // current exponent is the last one
    } t_sts;

endpackage

@@ sv/perfect_power_classifier_core.sv @@
// Top level: controller FSM and shared-multiplier datapath of the perfect power classifier.
// Sequence: integer square root, then for each exponent e a binary search over 1..root,
//   each step (16 max) a range check and up to e multiplies; a zero count skips to done.
// Throughput: one request at a time; the input stalls until the result is in the output
//   register, which may wait on the receiver. Reset (sync, active low): idle, no valid, count 4.
module perfect_power_classifier_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [ppc_pkg::CNT_W-1:0]   i_cfg_wr_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [ppc_pkg::VALUE_W-1:0] i_value,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [ppc_pkg::MASK_W-1:0]  o_power_mask
);
    import ppc_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    ppc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    ppc_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_value       (i_value),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_power_mask  (o_power_mask)
    );

endmodule

@@ sv/ppc_dpath.sv @@
// Datapath: config register, square root, binary search and power unit.
module ppc_dpath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [ppc_pkg::CNT_W-1:0]    i_cfg_wr_data,
    input  logic [ppc_pkg::VALUE_W-1:0]  i_value,
    input  ppc_pkg::t_cmd                i_cmd,
    output ppc_pkg::t_sts                o_sts,
    output logic [ppc_pkg::MASK_W-1:0]   o_power_mask
);
    import ppc_pkg::*;

    logic [CNT_W-1:0]   r_cfg;
    logic [VALUE_W-1:0] r_value;
    logic [ROOT_W-1:0]  r_root,  n_root;
    logic [BIT_W-1:0]   r_bit;
    logic [RANGE_W-1:0] r_lo,    r_hi;
    logic [ROOT_W-1:0]  r_mid;
    logic [VALUE_W-1:0] r_acc;
    logic [MCNT_W-1:0]  r_mcnt;
    logic [CNT_W-1:0]   r_k;
    logic [MASK_W-1:0]  r_mask;
    logic [MASK_W-1:0]  r_omask;

    logic [ROOT_W-1:0]  w_cand;
    logic [VALUE_W-1:0] w_op_a;
    logic [ROOT_W-1:0]  w_op_b;
    logic [PROD_W-1:0]  w_prod;
    logic [PROD_W-1:0]  w_value_ext;
    logic [RANGE_W-1:0] w_mid_wide;

    // Config register, to be written only while idle; the user must keep to this, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_wr_en) begin
            r_cfg <= i_cfg_wr_data;
        end
    end

    // Shared multiplier: cand*cand during sqrt, acc*mid during power
    assign w_cand = r_root | (ROOT_W'(1) << r_bit);

    always_comb begin
        if (i_cmd.sqrt_step) begin
            w_op_a = VALUE_W'(w_cand);
            w_op_b = w_cand;
        end else begin
            w_op_a = r_acc;
            w_op_b = r_mid;
        end
    end

    assign w_prod      = PROD_W'(w_op_a) * PROD_W'(w_op_b);
    assign w_value_ext = PROD_W'(r_value);

    // Midpoint of the search range
    assign w_mid_wide = r_lo + ((r_hi - r_lo) >> 1);

    always_comb begin
        n_root = r_root;
        if (w_prod <= w_value_ext) begin
            n_root = w_cand;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value <= i_value;
            r_root  <= '0;
            r_bit   <= BIT_W'(ROOT_W - 1);
            r_k     <= '0;
            r_mask  <= '0;
        end
        if (i_cmd.sqrt_step) begin
            r_root <= n_root;
            r_bit  <= r_bit - BIT_W'(1);
        end
        if (i_cmd.search_init) begin
            r_lo <= RANGE_W'(1);
            r_hi <= RANGE_W'(r_root);
        end
        if (i_cmd.mid_calc) begin
            r_mid  <= w_mid_wide[ROOT_W-1:0];
            r_acc  <= VALUE_W'(1);
            r_mcnt <= '0;
        end
        if (i_cmd.mul_acc) begin
            r_acc  <= w_prod[VALUE_W-1:0];
            r_mcnt <= r_mcnt + MCNT_W'(1);
        end
        if (i_cmd.go_hi) begin
            r_hi <= RANGE_W'(r_mid) - RANGE_W'(1);
        end
        if (i_cmd.go_lo) begin
            r_lo <= RANGE_W'(r_mid) + RANGE_W'(1);
        end
        if (i_cmd.set_match) begin
            r_mask[r_k] <= 1'b1;
        end
        if (i_cmd.next_exp) begin
            r_k <= r_k + CNT_W'(1);
        end
        if (i_cmd.out_load) begin
            r_omask <= r_mask;
        end
    end

    // Status back to the controller
    assign o_sts.count_zero = (r_cfg == '0);
    assign o_sts.sqrt_last  = (r_bit == '0);
    assign o_sts.range_ok   = (r_hi >= r_lo);
    assign o_sts.prod_gt    = (w_prod > w_value_ext);
    assign o_sts.prod_eq    = (w_prod == w_value_ext);
    assign o_sts.mul_last   = (r_mcnt == (MCNT_W'(r_k) + MCNT_W'(1)));
    assign o_sts.exp_last   = ((MCNT_W'(r_k) + MCNT_W'(1)) == MCNT_W'(r_cfg));

    assign o_power_mask = r_omask;

endmodule

@@ sv/ppc_ctrl.sv @@
// Controller: sequences sqrt, per-exponent binary search and result handoff.
`include "perfect_power_classifier_core_assert.svh"

module ppc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  ppc_pkg::t_sts i_sts,
    output ppc_pkg::t_cmd o_cmd
);
    import ppc_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SQRT  = 3'd1;
    localparam logic [2:0] S_SINIT = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_NEXT  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_ovalid, n_ovalid;

    // Next state and commands
    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid & i_out_stall;
        o_cmd    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.count_zero ? S_DONE : S_SQRT;
                end
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (i_sts.sqrt_last) begin
                    n_state = S_SINIT;
                end
            end
            S_SINIT: begin
                o_cmd.search_init = 1'b1;
                n_state           = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.range_ok) begin
                    o_cmd.mid_calc = 1'b1;
                    n_state        = S_MUL;
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_MUL: begin
                // overflow or too large ends this try early
                priority if (i_sts.prod_gt) begin
                    o_cmd.go_hi = 1'b1;
                    n_state     = S_CHECK;
                end else if (i_sts.mul_last) begin
                    if (i_sts.prod_eq) begin
                        o_cmd.set_match = 1'b1;
                        n_state         = S_NEXT;
                    end else begin
                        o_cmd.go_lo = 1'b1;
                        n_state     = S_CHECK;
                    end
                end else begin
                    o_cmd.mul_acc = 1'b1;
                end
            end
            S_NEXT: begin
                if (i_sts.exp_last) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.next_exp = 1'b1;
                    n_state        = S_SINIT;
                end
            end
            S_DONE: begin
                // wait for the output register to free up
                if (!r_ovalid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_ovalid       = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;

    // Checks
    `PPC_ASSERT_NXT(a_accept_starts, i_in_valid && (r_state == S_IDLE), r_state != S_IDLE, "request accepted but controller stayed idle")
    `PPC_ASSERT_NXT(a_done_holds, (r_state == S_DONE) && r_ovalid && i_out_stall, (r_state == S_DONE) && r_ovalid, "result dropped while output stalled")
    `PPC_ASSERT_IMP(a_valid_from_done, $rose(r_ovalid), $past(r_state) == S_DONE, "result valid raised outside done state")

endmodule

@@ bench/tb_perfect_power_classifier_core.sv @@
// Self-checking testbench for the perfect power classifier core.
`timescale 1ns / 1ps

module tb_perfect_power_classifier_core;
    import ppc_pkg::*;

    localparam int LONG_HOLD = 3000;       // receiver hold-off, in cycles
    localparam int NUM_SEGS  = 6;
    localparam logic [VALUE_W-1:0] MAX_VALUE = '1;

    // Directed row: count to program, value, and an optional typed-in mask
    typedef struct packed {
        logic [CNT_W-1:0]   count;
        logic [VALUE_W-1:0] value;
        logic               typed;
        logic [MASK_W-1:0]  mask;
    } t_dir_row;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [MASK_W-1:0]  mask;
    } t_mask_entry;

    localparam t_dir_row DIRECTED [0:19] = '{
        // reset count of four
        '{5'd4,  32'h0000_0000, 1'b1, 31'h0000_0000},
        '{5'd4,  32'h0000_0001, 1'b1, 31'h0000_000F},
        '{5'd4,  32'hFFFF_FFFF, 1'b0, 31'h0},
        '{5'd4,  32'h0001_0000, 1'b0, 31'h0},
        '{5'd4,  32'hFFFE_0001, 1'b0, 31'h0},
        // zero count: nothing tested
        '{5'd0,  32'h0000_0001, 1'b1, 31'h0000_0000},
        '{5'd0,  32'hFFFF_FFFF, 1'b1, 31'h0000_0000},
        '{5'd0,  32'h0001_0000, 1'b1, 31'h0000_0000},
        // squares only
        '{5'd1,  32'h0000_0004, 1'b1, 31'h0000_0001},
        '{5'd1,  32'h0000_0003, 1'b1, 31'h0000_0000},
        '{5'd1,  32'hFFFE_0001, 1'b1, 31'h0000_0001},
        '{5'd1,  32'h0000_0000, 1'b1, 31'h0000_0000},
        // full count
        '{5'd31, 32'h0000_0001, 1'b1, 31'h7FFF_FFFF},
        '{5'd31, 32'h0000_0000, 1'b1, 31'h0000_0000},
        '{5'd31, 32'h8000_0000, 1'b0, 31'h0},
        '{5'd31, 32'h4000_0000, 1'b0, 31'h0},
        '{5'd31, 32'd3486784401, 1'b0, 31'h0},
        '{5'd31, 32'hFFFF_FFFF, 1'b0, 31'h0},
        '{5'd31, 32'h0000_0002, 1'b0, 31'h0},
        '{5'd31, 32'h0001_0000, 1'b0, 31'h0}
    };

    localparam int SEG_ITEMS [NUM_SEGS] = '{40, 50, 50, 50, 50, 55};

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_wr_en = 1'b0;
    logic [CNT_W-1:0]     i_cfg_wr_data = CFG_RESET;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [VALUE_W-1:0]   i_value = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [MASK_W-1:0]    o_power_mask;

    t_mask_entry          pending_masks [$];
    logic [CNT_W-1:0]     active_count = CFG_RESET;
    int                   src_idle_pct = 0;
    int                   sink_stall_pct = 0;
    int                   mismatches = 0;
    int                   requests_sent = 0;
    int                   masks_checked = 0;
    int                   masks_nonzero = 0;
    int                   count_writes = 0;
    int                   hold_reqs = 0;
    int                   holds_done = 0;

    perfect_power_classifier_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_power_mask  (o_power_mask)
    );

    always #1 i_clk = ~i_clk;

    // Sign of base^e - n; a product past n stops the loop early
    function automatic int power_order(longint unsigned base, int e, longint unsigned n);
        longint unsigned acc;
        acc = 1;
        for (int i = 0; i < e; i++) begin
            if (acc > n / base) return 1;
            acc = acc * base;
        end
        if (acc == n) return 0;
        return (acc > n) ? 1 : -1;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned root;
        longint unsigned cand;
        root = 0;
        for (int b = ROOT_W - 1; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if (cand * cand <= n) root = cand;
        end
        return root;
    endfunction

    // Binary search for an integer e-th root in 1..floor(sqrt(n))
    function automatic bit has_int_root(longint unsigned n, int e);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        int              ord;
        lo = 1;
        hi = root_floor(n);
        while (hi >= lo) begin
            mid = lo + (hi - lo) / 2;
            ord = power_order(mid, e, n);
            if (ord == 0) return 1'b1;
            if (ord > 0) hi = mid - 1;
            else lo = mid + 1;
        end
        return 1'b0;
    endfunction

    function automatic logic [MASK_W-1:0] power_mask_of(logic [VALUE_W-1:0] v,
                                                        logic [CNT_W-1:0] count);
        logic [MASK_W-1:0] mask;
        int                tests;
        mask  = '0;
        tests = (count > MASK_W) ? MASK_W : int'(count);
        for (int k = 0; k < tests; k++) begin
            if (has_int_root(longint'(v), k + 2)) mask[k] = 1'b1;
        end
        return mask;
    endfunction

    // Exact power of a random base, sometimes nudged by one either way
    function automatic logic [VALUE_W-1:0] random_power();
        int              e;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned p;
        e  = ($urandom_range(3) == 0) ? $urandom_range(32, 2) : $urandom_range(6, 2);
        lo = 1;
        hi = 64'd1 << ROOT_W;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (power_order(mid, e, longint'(MAX_VALUE)) <= 0) lo = mid;
            else hi = mid - 1;
        end
        if ($urandom_range(1) == 0 && lo > 12) lo = 12;
        mid = $urandom_range(int'(lo), 1);
        p   = 1;
        repeat (e) p = p * mid;
        case ($urandom_range(3))
            0: begin
                if (p > 0) p = p - 1;
            end
            1: begin
                if (p < longint'(MAX_VALUE)) p = p + 1;
            end
            default: ;
        endcase
        return p[VALUE_W-1:0];
    endfunction

    function automatic logic [VALUE_W-1:0] random_value();
        int pick;
        pick = $urandom_range(19);
        if (pick < 10) return random_power();
        if (pick < 13) return VALUE_W'($urandom_range(40));
        if (pick < 15) return MAX_VALUE - VALUE_W'($urandom_range(255));
        return $urandom;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // Offer one request and record its expected mask once accepted
    task automatic send_request(input logic [VALUE_W-1:0] v, input logic typed,
                                input logic [MASK_W-1:0] typed_mask);
        t_mask_entry entry;
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_value    <= v;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        entry.value = v;
        entry.mask  = typed ? typed_mask : power_mask_of(v, active_count);
        pending_masks.insert(pending_masks.size(), entry);
        requests_sent++;
    endtask

    // Stop offering and wait for every outstanding mask
    task automatic drain();
        i_in_valid <= 1'b0;
        wait (pending_masks.size() == 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_count(input logic [CNT_W-1:0] count);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= count;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        active_count  = count;
        count_writes++;
    endtask

    // Result side: check accepted masks, then pick next cycle's stall
    initial begin : result_sink
        int          hold_left;
        t_mask_entry want;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                if (pending_masks.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result, mask %h", o_power_mask));
                end else begin
                    want = pending_masks.pop_front();
                    masks_checked++;
                    if (want.mask != '0) masks_nonzero++;
                    if (o_power_mask !== want.mask)
                        flag_mismatch($sformatf("value %0d: mask %h, expected %h",
                                                want.value, o_power_mask, want.mask));
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (holds_done != hold_reqs) begin
                holds_done++;
                hold_left = LONG_HOLD - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < sink_stall_pct);
            end
        end
    end

    // Request side: directed table, then random segments
    initial begin : request_source
        t_dir_row         row;
        logic [CNT_W-1:0] seg_count;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[i]) begin
            row = DIRECTED[i];
            if (row.count != active_count) write_count(row.count);
            send_request(row.value, row.typed, row.mask);
        end

        for (int seg = 0; seg < NUM_SEGS; seg++) begin
            // two segments per idle pattern
            case (seg / 2)
                0: begin
                    src_idle_pct   = 31;
                    sink_stall_pct = 76;
                end
                1: begin
                    src_idle_pct   = 76;
                    sink_stall_pct = 31;
                end
                default: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
            endcase
            case (seg)
                0: seg_count = 5'd31;
                1: seg_count = 5'd3;
                2: seg_count = 5'd1;
                3: seg_count = CNT_W'($urandom_range(8, 5));
                4: seg_count = CFG_RESET;
                default: seg_count = CNT_W'($urandom_range(16, 9));
            endcase
            write_count(seg_count);
            // long receiver hold-off while requests keep coming
            if (seg == 4) hold_reqs++;
            for (int n = 0; n < SEG_ITEMS[seg]; n++) begin
                if (seg == 2 && n == 25) drain();
                send_request(random_value(), 1'b0, '0);
            end
        end

        drain();
        repeat (200) @(posedge i_clk);
        $display("Sent %0d requests under %0d exponent count writes; checked %0d masks",
                 requests_sent, count_writes, masks_checked);
        $display("%0d masks flagged a perfect power; idle, stall and hold-off phases covered",
                 masks_nonzero);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Hard limit on run time
    initial begin : run_limit
        #100_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/ppc_pkg.sv
sv/ppc_dpath.sv
sv/ppc_ctrl.sv
sv/perfect_power_classifier_core.sv
bench/tb_perfect_power_classifier_core.sv
